// ----- rtl/q2e_pkg.sv -----
// Shared constants, types and tables for the quaternion to Euler angle pipeline.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

   localparam int CORDIC_STAGES = 16;

   localparam int QW  = 16;   // quaternion component width
   localparam int PW  = 32;   // signed product of two components
   localparam int AW  = 35;   // arctangent argument width
   localparam int CW  = 44;   // CORDIC x/y datapath width
   localparam int ZW  = 34;   // CORDIC angle accumulator width
   localparam int NW  = 33;   // squared norm width
   localparam int RW  = 34;   // divider remainder width
   localparam int DQW = 31;   // quotient width, Q1.30 magnitude
   localparam int SVW = 61;   // square root radicand width
   localparam int SRW = 62;   // square root working root width
   localparam int SW  = 32;   // signed arcsine argument width
   localparam int MW  = 60;   // scaled angle product width
   localparam int OW  = 16;   // output angle width

   localparam int NORM_STEPS  = 7;
   localparam int DIV_STEPS   = DQW;
   localparam int SQRT_STEPS  = 31;
   localparam int PITCH_PREFIX = DIV_STEPS + SQRT_STEPS + 3;
   localparam int FRONT_LAT   = 2;
   localparam int CORDIC_LAT  = 1 + NORM_STEPS + CORDIC_STAGES;
   localparam int UNIT_LAT    = 2;
   localparam int FLAG_LAT    = PITCH_PREFIX + CORDIC_LAT + UNIT_LAT;
   localparam int TOTAL_LAT   = FRONT_LAT + FLAG_LAT;

   localparam logic signed [ZW-1:0] ANG_PI = 34'sd1686629713;
   localparam logic [24:0] DEG_MUL = 25'd15019745;
   localparam int DEG_SHIFT = 40;
   localparam int RAD_SHIFT = 16;
   localparam logic [DQW-1:0] ONE_Q30 = DQW'(1) << 30;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } cordic_vec_type;

   typedef struct packed {
      logic [RW-1:0]  rem;
      logic [DQW-1:0] quo;
      logic [NW-1:0]  norm;
      logic           neg;
      logic           sat;
   } div_state_type;

   typedef struct packed {
      logic [SVW-1:0]       rad;
      logic [SRW-1:0]       root;
      logic signed [SW-1:0] sine;
   } sqrt_state_type;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ZW-1:0] a;
      case (idx)
         5'd0:  a = 34'sd421657428;
         5'd1:  a = 34'sd248918915;
         5'd2:  a = 34'sd131521918;
         5'd3:  a = 34'sd66762579;
         5'd4:  a = 34'sd33510843;
         5'd5:  a = 34'sd16771758;
         5'd6:  a = 34'sd8387925;
         5'd7:  a = 34'sd4194219;
         5'd8:  a = 34'sd2097141;
         5'd9:  a = 34'sd1048575;
         5'd10: a = 34'sd524288;
         5'd11: a = 34'sd262144;
         5'd12: a = 34'sd131072;
         5'd13: a = 34'sd65536;
         5'd14: a = 34'sd32768;
         5'd15: a = 34'sd16384;
         5'd16: a = 34'sd8192;
         5'd17: a = 34'sd4096;
         5'd18: a = 34'sd2048;
         5'd19: a = 34'sd1024;
         5'd20: a = 34'sd512;
         5'd21: a = 34'sd256;
         5'd22: a = 34'sd128;
         5'd23: a = 34'sd64;
         default: a = '0;
      endcase
      return a;
   endfunction

   // Normalisation is a binary search for the doubling count, finished by one
   // last doubling that lifts the larger magnitude to at least 2^40.
   function automatic logic [5:0] norm_shift(input logic [2:0] idx);
      logic [5:0] s;
      case (idx)
         3'd0: s = 6'd32;
         3'd1: s = 6'd16;
         3'd2: s = 6'd8;
         3'd3: s = 6'd4;
         3'd4: s = 6'd2;
         default: s = 6'd1;
      endcase
      return s;
   endfunction

   function automatic logic [5:0] norm_limit(input logic [2:0] idx);
      logic [5:0] l;
      case (idx)
         3'd0: l = 6'd8;
         3'd1: l = 6'd24;
         3'd2: l = 6'd32;
         3'd3: l = 6'd36;
         3'd4: l = 6'd38;
         3'd5: l = 6'd39;
         default: l = 6'd40;
      endcase
      return l;
   endfunction

   // True when the magnitude of v is below 2^lim.
   function automatic logic small_mag(input logic signed [CW-1:0] v, input logic [5:0] lim);
      logic signed [CW-1:0] hi;
      logic [CW-1:0] mask;
      hi   = v >>> lim;
      mask = (CW'(1) << lim) - CW'(1);
      return (hi == '0) || ((hi == '1) && ((v & mask) != '0));
   endfunction

endpackage
`default_nettype wire

// ----- rtl/q2e_front.sv -----
// Front end: component products, then the sums that feed the three angles.
// Depends on q2e_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q2e_front (
   input  wire logic                           clock,
   input  wire logic                           advance,
   input  wire logic signed [q2e_pkg::QW-1:0]  quat_real,
   input  wire logic signed [q2e_pkg::QW-1:0]  quat_i,
   input  wire logic signed [q2e_pkg::QW-1:0]  quat_j,
   input  wire logic signed [q2e_pkg::QW-1:0]  quat_k,
   output logic        [q2e_pkg::NW-1:0]       norm,
   output logic signed [q2e_pkg::AW-1:0]       numer,
   output logic signed [q2e_pkg::AW-1:0]       yaw_y,
   output logic signed [q2e_pkg::AW-1:0]       yaw_x,
   output logic signed [q2e_pkg::AW-1:0]       roll_y,
   output logic signed [q2e_pkg::AW-1:0]       roll_x,
   output logic                                quat_zero
);

   logic signed [q2e_pkg::PW-1:0] rr_ff, ii_ff, jj_ff, kk_ff;
   logic signed [q2e_pkg::PW-1:0] jr_ff, ik_ff, ij_ff, kr_ff, jk_ff, ir_ff;
   logic zero1_ff;

   logic signed [q2e_pkg::AW-1:0] norm_in, numer_in, yaw_y_in, yaw_x_in, roll_y_in, roll_x_in;
   logic signed [q2e_pkg::AW-1:0] norm_ff;
   logic signed [q2e_pkg::AW-1:0] numer_ff, yaw_y_ff, yaw_x_ff, roll_y_ff, roll_x_ff;
   logic zero2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rr_ff <= q2e_pkg::PW'(quat_real * quat_real);
         ii_ff <= q2e_pkg::PW'(quat_i * quat_i);
         jj_ff <= q2e_pkg::PW'(quat_j * quat_j);
         kk_ff <= q2e_pkg::PW'(quat_k * quat_k);
         jr_ff <= q2e_pkg::PW'(quat_j * quat_real);
         ik_ff <= q2e_pkg::PW'(quat_i * quat_k);
         ij_ff <= q2e_pkg::PW'(quat_i * quat_j);
         kr_ff <= q2e_pkg::PW'(quat_k * quat_real);
         jk_ff <= q2e_pkg::PW'(quat_j * quat_k);
         ir_ff <= q2e_pkg::PW'(quat_i * quat_real);
         zero1_ff <= (quat_real == '0) && (quat_i == '0) && (quat_j == '0) && (quat_k == '0);
      end
   end

   always_comb begin
      norm_in   = q2e_pkg::AW'(rr_ff) + q2e_pkg::AW'(ii_ff)
                + q2e_pkg::AW'(jj_ff) + q2e_pkg::AW'(kk_ff);
      numer_in  = (q2e_pkg::AW'(jr_ff) - q2e_pkg::AW'(ik_ff)) <<< 1;
      yaw_y_in  = (q2e_pkg::AW'(ij_ff) + q2e_pkg::AW'(kr_ff)) <<< 1;
      yaw_x_in  = q2e_pkg::AW'(ii_ff) - q2e_pkg::AW'(jj_ff)
                - q2e_pkg::AW'(kk_ff) + q2e_pkg::AW'(rr_ff);
      roll_y_in = (q2e_pkg::AW'(jk_ff) + q2e_pkg::AW'(ir_ff)) <<< 1;
      roll_x_in = q2e_pkg::AW'(rr_ff) - q2e_pkg::AW'(ii_ff)
                - q2e_pkg::AW'(jj_ff) + q2e_pkg::AW'(kk_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         norm_ff   <= norm_in;
         numer_ff  <= numer_in;
         yaw_y_ff  <= yaw_y_in;
         yaw_x_ff  <= yaw_x_in;
         roll_y_ff <= roll_y_in;
         roll_x_ff <= roll_x_in;
         zero2_ff  <= zero1_ff;
      end
   end

   assign norm      = norm_ff[q2e_pkg::NW-1:0];
   assign numer     = numer_ff;
   assign yaw_y     = yaw_y_ff;
   assign yaw_x     = yaw_x_ff;
   assign roll_y    = roll_y_ff;
   assign roll_x    = roll_x_ff;
   assign quat_zero = zero2_ff;

endmodule
`default_nettype wire

// ----- rtl/q2e_div_cell.sv -----
// One restoring division cell: one quotient bit of the arcsine argument.
// Depends on q2e_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q2e_div_cell (
   input  wire logic                   clock,
   input  wire logic                   advance,
   input  wire q2e_pkg::div_state_type state_in,
   output q2e_pkg::div_state_type      state_out
);

   q2e_pkg::div_state_type step_in, step_ff;
   logic [q2e_pkg::RW-1:0] divisor;
   logic take;

   always_comb begin
      divisor = {1'b0, state_in.norm};
      take    = state_in.rem >= divisor;
      step_in = state_in;
      step_in.rem = (take ? state_in.rem - divisor : state_in.rem) << 1;
      step_in.quo = {state_in.quo[q2e_pkg::DQW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         step_ff <= step_in;
      end
   end

   assign state_out = step_ff;

endmodule
`default_nettype wire

// ----- rtl/q2e_sqrt_cell.sv -----
// One digit-by-digit integer square root cell, resolving one root bit.
// Depends on q2e_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q2e_sqrt_cell (
   input  wire logic                    clock,
   input  wire logic                    advance,
   input  wire logic [q2e_pkg::SRW-1:0] bit_val,
   input  wire q2e_pkg::sqrt_state_type state_in,
   output q2e_pkg::sqrt_state_type      state_out
);

   q2e_pkg::sqrt_state_type step_in, step_ff;
   logic [q2e_pkg::SRW-1:0] trial;
   logic take;

   always_comb begin
      trial   = state_in.root + bit_val;
      take    = {1'b0, state_in.rad} >= trial;
      step_in = state_in;
      if (take) begin
         step_in.rad  = state_in.rad - trial[q2e_pkg::SVW-1:0];
         step_in.root = (state_in.root >> 1) + bit_val;
      end else begin
         step_in.root = state_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         step_ff <= step_in;
      end
   end

   assign state_out = step_ff;

endmodule
`default_nettype wire

// ----- rtl/q2e_cordic_cell.sv -----
// One vectoring CORDIC micro-rotation; the stage index is tied off by the parent.
// Depends on q2e_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q2e_cordic_cell (
   input  wire logic                    clock,
   input  wire logic                    advance,
   input  wire logic [4:0]              stage_idx,
   input  wire q2e_pkg::cordic_vec_type vec_in,
   output q2e_pkg::cordic_vec_type      vec_out
);

   q2e_pkg::cordic_vec_type rot_in, rot_ff;
   logic signed [q2e_pkg::CW-1:0] dx, dy;
   logic signed [q2e_pkg::ZW-1:0] da;

   always_comb begin
      dx = vec_in.y >>> stage_idx;
      dy = vec_in.x >>> stage_idx;
      da = q2e_pkg::atan_entry(stage_idx);
      rot_in = vec_in;
      if (!vec_in.y[q2e_pkg::CW-1]) begin
         rot_in.x = vec_in.x + dx;
         rot_in.y = vec_in.y - dy;
         rot_in.z = vec_in.z + da;
      end else begin
         rot_in.x = vec_in.x - dx;
         rot_in.y = vec_in.y + dy;
         rot_in.z = vec_in.z - da;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rot_ff <= rot_in;
      end
   end

   assign vec_out = rot_ff;

endmodule
`default_nettype wire

// ----- rtl/q2e_cordic.sv -----
// Two-argument arctangent: quadrant fold, normalisation stages, then a row
// of CORDIC cells. Depends on q2e_pkg and q2e_cordic_cell.
`timescale 1ns / 1ps
`default_nettype none
module q2e_cordic (
   input  wire logic                          clock,
   input  wire logic                          advance,
   input  wire logic signed [q2e_pkg::AW-1:0] arg_y,
   input  wire logic signed [q2e_pkg::AW-1:0] arg_x,
   output logic signed [q2e_pkg::ZW-1:0]      angle
);

   localparam int CHAIN = q2e_pkg::NORM_STEPS + q2e_pkg::CORDIC_STAGES;

   q2e_pkg::cordic_vec_type pre_in, pre_ff;
   q2e_pkg::cordic_vec_type chain [0:CHAIN];

   always_comb begin
      pre_in.zero = (arg_x == '0) && (arg_y == '0);
      if (arg_x[q2e_pkg::AW-1]) begin
         pre_in.x = -q2e_pkg::CW'(arg_x);
         pre_in.y = -q2e_pkg::CW'(arg_y);
         pre_in.z = arg_y[q2e_pkg::AW-1] ? -q2e_pkg::ANG_PI : q2e_pkg::ANG_PI;
      end else begin
         pre_in.x = q2e_pkg::CW'(arg_x);
         pre_in.y = q2e_pkg::CW'(arg_y);
         pre_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pre_ff <= pre_in;
      end
   end

   assign chain[0] = pre_ff;

   for (genvar s = 0; s < q2e_pkg::NORM_STEPS; s++) begin : g_norm
      localparam logic [5:0] SHIFT = q2e_pkg::norm_shift(3'(s));
      localparam logic [5:0] LIMIT = q2e_pkg::norm_limit(3'(s));
      q2e_pkg::cordic_vec_type norm_in, norm_ff;
      logic take;

      always_comb begin
         take = q2e_pkg::small_mag(chain[s].x, LIMIT) && q2e_pkg::small_mag(chain[s].y, LIMIT);
         norm_in = chain[s];
         if (take) begin
            norm_in.x = chain[s].x <<< SHIFT;
            norm_in.y = chain[s].y <<< SHIFT;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            norm_ff <= norm_in;
         end
      end

      assign chain[s+1] = norm_ff;
   end

   for (genvar i = 0; i < q2e_pkg::CORDIC_STAGES; i++) begin : g_cell
      q2e_cordic_cell u_cell (
         .clock     (clock),
         .advance   (advance),
         .stage_idx (5'(i)),
         .vec_in    (chain[q2e_pkg::NORM_STEPS+i]),
         .vec_out   (chain[q2e_pkg::NORM_STEPS+i+1])
      );
   end

   assign angle = chain[CHAIN].zero ? '0 : chain[CHAIN].z;

endmodule
`default_nettype wire

// ----- rtl/q2e_unit.sv -----
// Scales a radian angle to the selected output unit, rounds and saturates.
// Depends on q2e_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q2e_unit (
   input  wire logic                          clock,
   input  wire logic                          advance,
   input  wire logic                          degrees,
   input  wire logic                          force_zero,
   input  wire logic signed [q2e_pkg::ZW-1:0] angle_in,
   output logic signed [q2e_pkg::OW-1:0]      angle_out
);

   logic signed [q2e_pkg::MW-1:0] prod_in, prod_ff;
   logic deg_ff, zero_ff;
   logic [q2e_pkg::MW-1:0] mag, rnd;
   logic [q2e_pkg::OW:0] lim;
   logic signed [q2e_pkg::OW-1:0] out_in, out_ff;

   always_comb begin
      if (degrees) begin
         prod_in = angle_in * $signed({1'b0, q2e_pkg::DEG_MUL});
      end else begin
         prod_in = q2e_pkg::MW'(angle_in);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         deg_ff  <= degrees;
         zero_ff <= force_zero;
      end
   end

   // Round half away from zero on the magnitude, then clamp asymmetrically.
   always_comb begin
      mag = prod_ff[q2e_pkg::MW-1] ? q2e_pkg::MW'(-prod_ff) : q2e_pkg::MW'(prod_ff);
      if (deg_ff) begin
         rnd = (mag + (q2e_pkg::MW'(1) << (q2e_pkg::DEG_SHIFT - 1))) >> q2e_pkg::DEG_SHIFT;
      end else begin
         rnd = (mag + (q2e_pkg::MW'(1) << (q2e_pkg::RAD_SHIFT - 1))) >> q2e_pkg::RAD_SHIFT;
      end
      if (prod_ff[q2e_pkg::MW-1]) begin
         lim    = (rnd > q2e_pkg::MW'(32768)) ? 17'd32768 : rnd[q2e_pkg::OW:0];
         out_in = q2e_pkg::OW'(-$signed(lim));
      end else begin
         lim    = (rnd > q2e_pkg::MW'(32767)) ? 17'd32767 : rnd[q2e_pkg::OW:0];
         out_in = q2e_pkg::OW'(lim);
      end
      if (zero_ff) begin
         out_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign angle_out = out_ff;

endmodule
`default_nettype wire

// ----- rtl/quaternion_to_euler.sv -----
// Quaternion to ZYX Euler angles (yaw, pitch, roll), fully pipelined.
// Depends on q2e_pkg and all q2e_* modules.
//
// One quaternion is taken every cycle while req_ready is high; its
// angles pass through 2 front-end stages, 65 stages for the pitch division
// and square root rows, 8 + CORDIC_STAGES stages of arctangent and 2 output
// scaling stages. The three arctangents run side by side in rows of cells;
// yaw and roll arguments wait in delay lines for the pitch argument. When a
// finished result is not taken, the whole pipeline holds and req_ready drops
// until rsp_ready returns. The unit register is read at the output and should
// be changed only with the pipeline empty.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [q2e_pkg::QW-1:0] req_quat_real,
   input  wire logic signed [q2e_pkg::QW-1:0] req_quat_i,
   input  wire logic signed [q2e_pkg::QW-1:0] req_quat_j,
   input  wire logic signed [q2e_pkg::QW-1:0] req_quat_k,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [q2e_pkg::OW-1:0]      rsp_yaw_angle,
   output logic signed [q2e_pkg::OW-1:0]      rsp_pitch_angle,
   output logic signed [q2e_pkg::OW-1:0]      rsp_roll_angle,
   output logic                               rsp_pitch_saturated,
   output logic                               rsp_zero_quaternion,
   input  wire logic                          csr_wr_en,
   input  wire logic                          csr_wr_data
);

   localparam int PP = q2e_pkg::PITCH_PREFIX;
   localparam int FL = q2e_pkg::FLAG_LAT;

   logic advance;
   logic degrees_ff;
   logic [q2e_pkg::TOTAL_LAT-1:0] valid_ff;
   logic [FL-1:0] zero_ff;
   logic [FL-2:0] sat_ff;

   logic        [q2e_pkg::NW-1:0] f_norm;
   logic signed [q2e_pkg::AW-1:0] f_numer, f_yaw_y, f_yaw_x, f_roll_y, f_roll_x;
   logic f_zero;

   logic signed [q2e_pkg::AW-1:0] yy_ff [0:PP-1];
   logic signed [q2e_pkg::AW-1:0] yx_ff [0:PP-1];
   logic signed [q2e_pkg::AW-1:0] ry_ff [0:PP-1];
   logic signed [q2e_pkg::AW-1:0] rx_ff [0:PP-1];

   logic signed [q2e_pkg::AW-1:0] num_mag;
   q2e_pkg::div_state_type div_in, div_ff;
   q2e_pkg::div_state_type div_chain [0:q2e_pkg::DIV_STEPS];

   logic [q2e_pkg::DQW-1:0] s_mag;
   logic [2*q2e_pkg::DQW-1:0] sq_in, sq_ff;
   logic signed [q2e_pkg::SW-1:0] sine_in, sine_ff;
   q2e_pkg::sqrt_state_type rad_in, rad_ff;
   q2e_pkg::sqrt_state_type sqrt_chain [0:q2e_pkg::SQRT_STEPS];

   logic signed [q2e_pkg::AW-1:0] pitch_y, pitch_x;
   logic signed [q2e_pkg::ZW-1:0] yaw_z, pitch_z, roll_z;
   logic force_zero;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         degrees_ff <= 1'b1;
      end else if (csr_wr_en) begin
         degrees_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[q2e_pkg::TOTAL_LAT-2:0], req_valid};
      end
   end

   q2e_front u_front (
      .clock     (clock),
      .advance   (advance),
      .quat_real (req_quat_real),
      .quat_i    (req_quat_i),
      .quat_j    (req_quat_j),
      .quat_k    (req_quat_k),
      .norm      (f_norm),
      .numer     (f_numer),
      .yaw_y     (f_yaw_y),
      .yaw_x     (f_yaw_x),
      .roll_y    (f_roll_y),
      .roll_x    (f_roll_x),
      .quat_zero (f_zero)
   );

   // Yaw and roll arguments wait here while the pitch argument is formed.
   always_ff @(posedge clock) begin
      if (advance) begin
         yy_ff[0] <= f_yaw_y;
         yx_ff[0] <= f_yaw_x;
         ry_ff[0] <= f_roll_y;
         rx_ff[0] <= f_roll_x;
         for (int d = 1; d < PP; d++) begin
            yy_ff[d] <= yy_ff[d-1];
            yx_ff[d] <= yx_ff[d-1];
            ry_ff[d] <= ry_ff[d-1];
            rx_ff[d] <= rx_ff[d-1];
         end
      end
   end

   always_comb begin
      num_mag     = f_numer[q2e_pkg::AW-1] ? -f_numer : f_numer;
      div_in.rem  = q2e_pkg::RW'(num_mag[q2e_pkg::NW-1:0]);
      div_in.quo  = '0;
      div_in.norm = f_norm;
      div_in.neg  = f_numer[q2e_pkg::AW-1];
      div_in.sat  = num_mag[q2e_pkg::NW-1:0] > f_norm;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff <= div_in;
      end
   end

   assign div_chain[0] = div_ff;

   for (genvar t = 0; t < q2e_pkg::DIV_STEPS; t++) begin : g_div
      q2e_div_cell u_div (
         .clock     (clock),
         .advance   (advance),
         .state_in  (div_chain[t]),
         .state_out (div_chain[t+1])
      );
   end

   always_comb begin
      s_mag   = div_chain[q2e_pkg::DIV_STEPS].sat ? q2e_pkg::ONE_Q30
                                                  : div_chain[q2e_pkg::DIV_STEPS].quo;
      sq_in   = s_mag * s_mag;
      sine_in = div_chain[q2e_pkg::DIV_STEPS].neg ? -q2e_pkg::SW'(s_mag) : q2e_pkg::SW'(s_mag);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff   <= sq_in;
         sine_ff <= sine_in;
      end
   end

   always_comb begin
      rad_in.rad  = (q2e_pkg::SVW'(1) << (q2e_pkg::SVW - 1)) - sq_ff[q2e_pkg::SVW-1:0];
      rad_in.root = '0;
      rad_in.sine = sine_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff <= rad_in;
      end
   end

   assign sqrt_chain[0] = rad_ff;

   for (genvar t = 0; t < q2e_pkg::SQRT_STEPS; t++) begin : g_sqrt
      localparam logic [q2e_pkg::SRW-1:0] BIT =
         q2e_pkg::SRW'(1) << (2 * (q2e_pkg::SQRT_STEPS - 1 - t));
      q2e_sqrt_cell u_sqrt (
         .clock     (clock),
         .advance   (advance),
         .bit_val   (BIT),
         .state_in  (sqrt_chain[t]),
         .state_out (sqrt_chain[t+1])
      );
   end

   assign pitch_y = q2e_pkg::AW'(sqrt_chain[q2e_pkg::SQRT_STEPS].sine);
   assign pitch_x = $signed({4'b0, sqrt_chain[q2e_pkg::SQRT_STEPS].root[q2e_pkg::DQW-1:0]});

   q2e_cordic u_yaw (
      .clock (clock), .advance (advance),
      .arg_y (yy_ff[PP-1]), .arg_x (yx_ff[PP-1]), .angle (yaw_z)
   );

   q2e_cordic u_pitch (
      .clock (clock), .advance (advance),
      .arg_y (pitch_y), .arg_x (pitch_x), .angle (pitch_z)
   );

   q2e_cordic u_roll (
      .clock (clock), .advance (advance),
      .arg_y (ry_ff[PP-1]), .arg_x (rx_ff[PP-1]), .angle (roll_z)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         zero_ff <= {zero_ff[FL-2:0], f_zero};
         sat_ff  <= {sat_ff[FL-3:0], div_ff.sat};
      end
   end

   assign force_zero = zero_ff[FL - q2e_pkg::UNIT_LAT - 1];

   q2e_unit u_yaw_unit (
      .clock (clock), .advance (advance), .degrees (degrees_ff),
      .force_zero (force_zero), .angle_in (yaw_z), .angle_out (rsp_yaw_angle)
   );

   q2e_unit u_pitch_unit (
      .clock (clock), .advance (advance), .degrees (degrees_ff),
      .force_zero (force_zero), .angle_in (pitch_z), .angle_out (rsp_pitch_angle)
   );

   q2e_unit u_roll_unit (
      .clock (clock), .advance (advance), .degrees (degrees_ff),
      .force_zero (force_zero), .angle_in (roll_z), .angle_out (rsp_roll_angle)
   );

   assign rsp_valid           = valid_ff[q2e_pkg::TOTAL_LAT-1];
   assign rsp_zero_quaternion = zero_ff[FL-1];
   assign rsp_pitch_saturated = sat_ff[FL-2] && !zero_ff[FL-1];

endmodule
`default_nettype wire

// ----- rtl/q2e_checker.sv -----
// Port-level checks for the quaternion to Euler block, bound to its top level.
// Depends on q2e_pkg and quaternion_to_euler.
`timescale 1ns / 1ps
`default_nettype none
module q2e_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic signed [q2e_pkg::OW-1:0] rsp_yaw_angle,
   input wire logic signed [q2e_pkg::OW-1:0] rsp_pitch_angle,
   input wire logic signed [q2e_pkg::OW-1:0] rsp_roll_angle,
   input wire logic                          rsp_pitch_saturated,
   input wire logic                          rsp_zero_quaternion
);

   // A zero quaternion beat carries zero angles and no saturation.
   a_zero_beat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_quaternion |->
         rsp_yaw_angle == '0 && rsp_pitch_angle == '0 && rsp_roll_angle == '0
         && !rsp_pitch_saturated)
      else $error("zero quaternion beat with non-zero angles or saturation");

   // The pipeline holds, and takes nothing in, while a result waits.
   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

   a_empty_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat straight after reset");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_yaw_angle)
         && $stable(rsp_pitch_angle) && $stable(rsp_roll_angle))
      else $error("stalled result beat changed");

endmodule

bind quaternion_to_euler q2e_checker u_q2e_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_yaw_angle       (rsp_yaw_angle),
   .rsp_pitch_angle     (rsp_pitch_angle),
   .rsp_roll_angle      (rsp_roll_angle),
   .rsp_pitch_saturated (rsp_pitch_saturated),
   .rsp_zero_quaternion (rsp_zero_quaternion)
);
`default_nettype wire
